>>> rtl/hbmprs_pkg.sv
// Package for the per-bank refresh scheduler: item types, register indexes
// and reset values of the configuration registers. No dependencies.
package hbmprs_pkg;

   localparam int TIME_W = 48;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr[4:2].
   localparam logic [2:0] REG_REFRESH_INTERVAL   = 3'd0;
   localparam logic [2:0] REG_RECOVERY_TIME      = 3'd1;
   localparam logic [2:0] REG_STACK_IDS_IN_USE   = 3'd2;
   localparam logic [2:0] REG_BLOCK_PER_STACK_ID = 3'd3;
   localparam logic [2:0] REG_BANK_GROUP_SHIFT   = 3'd4;

   localparam logic [15:0] RESET_REFRESH_INTERVAL   = 16'd1950;
   localparam logic [11:0] RESET_RECOVERY_TIME      = 12'd280;
   localparam logic [2:0]  RESET_STACK_IDS_IN_USE   = 3'd1;
   localparam logic        RESET_BLOCK_PER_STACK_ID = 1'b1;
   localparam logic [2:0]  RESET_BANK_GROUP_SHIFT   = 3'd2;
   localparam logic [2:0]  MAX_BANK_GROUP_SHIFT     = 3'd4;

   typedef struct packed {
      logic       accept;
      logic       issue_valid;
      logic       issue_scope;
      logic [5:0] issue_flat_bank;
   } hbmprs_req_type;

   typedef struct packed {
      logic       offer_valid;
      logic       offer_sent;
      logic       offer_scope;
      logic [1:0] offer_stack_id;
      logic [3:0] offer_bank_group;
      logic [3:0] offer_bank;
   } hbmprs_rsp_type;

endpackage

>>> rtl/hbm_per_bank_refresh_scheduler.sv
// Per-bank refresh scheduler: one item per controller clock tick.
// Depends on hbmprs_pkg for item types and register constants.
// The result of an item is registered and shown in the cycle after acceptance.
// Throughput: one item per cycle unless rsp_ready stalls; the round seeding, the
// queue head and the boundary tracking are all updated by one level of logic
// between registers. Reset: synchronous, active high; clears all scheduler state
// and loads the register reset values at once, so there is no clearing pass.
module hbm_per_bank_refresh_scheduler #(
   parameter int SCOPES             = 2,
   parameter int STACK_IDS          = 4,
   parameter int BANKS_PER_STACK_ID = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hbmprs_pkg::hbmprs_req_type          req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hbmprs_pkg::hbmprs_rsp_type          rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hbmprs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hbmprs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hbmprs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import hbmprs_pkg::*;

   localparam int SC_W   = $clog2(SCOPES + 1);
   localparam int SID_W  = (STACK_IDS > 1) ? $clog2(STACK_IDS) : 1;
   localparam int SCNT_W = $clog2(STACK_IDS + 1);
   localparam int IB_W   = $clog2(BANKS_PER_STACK_ID);
   localparam int FB_W   = $clog2(STACK_IDS * BANKS_PER_STACK_ID);
   localparam int CMP_W  = (FB_W > 6) ? FB_W : 6;
   localparam int EW     = (IB_W > 4) ? IB_W : 4;

   // Configuration registers.
   logic [15:0] refresh_interval_ff;
   logic [11:0] recovery_time_ff;
   logic [2:0]  stack_ids_in_use_ff;
   logic        block_per_stack_id_ff;
   logic [2:0]  bank_group_shift_ff;

   // Scheduler state.
   logic [TIME_W-1:0] clock_count_ff, clock_count_in;
   logic [TIME_W-1:0] next_time_ff, next_time_in;
   logic [SID_W-1:0]  round_sid_ff, round_sid_in;
   logic [IB_W-1:0]   round_ib_ff, round_ib_in;
   logic [SID_W-1:0]  queue_sid_ff, queue_sid_in;
   logic [IB_W-1:0]   queue_ib_ff, queue_ib_in;
   logic [SC_W-1:0]   queue_scope_ff, queue_scope_in;
   logic              awaiting_ff [SCOPES];
   logic              awaiting_in [SCOPES];
   logic [FB_W-1:0]   boundary_bank_ff [SCOPES];
   logic [FB_W-1:0]   boundary_bank_in [SCOPES];
   logic [TIME_W-1:0] allowed_time_ff [SCOPES];
   logic [TIME_W-1:0] allowed_time_in [SCOPES];

   logic              rsp_valid_ff, rsp_valid_in;
   hbmprs_rsp_type    rsp_item_ff, rsp_item_in;

   // Step logic.
   logic              step_fire;
   logic              csr_write;
   logic [2:0]        csr_index;
   logic [TIME_W-1:0] clock_next;
   logic [SCNT_W-1:0] stacks_used;
   logic [SID_W-1:0]  last_sid;
   logic              seed_ok;
   logic              queue_busy;
   logic              head_valid;
   logic [SID_W-1:0]  head_sid;
   logic [IB_W-1:0]   head_ib;
   logic [SC_W-1:0]   head_scope;
   logic [FB_W-1:0]   head_flat;
   logic              sid_block_end;
   logic              head_boundary;
   logic [2:0]        shift_used;
   logic [EW-1:0]     head_ib_ext;
   logic [EW-1:0]     group_ext;
   logic [EW-1:0]     bank_ext;

   assign step_fire = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;
   assign clock_next = clock_count_ff + TIME_W'(1);

   always_comb begin
      if (stack_ids_in_use_ff == 3'd0) begin
         stacks_used = SCNT_W'(1);
      end else if (32'(stack_ids_in_use_ff) > STACK_IDS) begin
         stacks_used = SCNT_W'(STACK_IDS);
      end else begin
         stacks_used = SCNT_W'(stack_ids_in_use_ff);
      end
   end

   assign last_sid   = SID_W'(stacks_used - SCNT_W'(1));
   assign shift_used = (bank_group_shift_ff > MAX_BANK_GROUP_SHIFT) ?
                       MAX_BANK_GROUP_SHIFT : bank_group_shift_ff;

   always_comb begin
      clock_count_in = clock_count_ff;
      next_time_in   = next_time_ff;
      round_sid_in   = round_sid_ff;
      round_ib_in    = round_ib_ff;
      queue_sid_in   = queue_sid_ff;
      queue_ib_in    = queue_ib_ff;
      queue_scope_in = queue_scope_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_item_in    = rsp_item_ff;
      seed_ok        = 1'b1;
      head_valid     = 1'b0;
      head_sid       = queue_sid_ff;
      head_ib        = queue_ib_ff;
      head_scope     = queue_scope_ff;
      head_flat      = '0;
      sid_block_end  = 1'b0;
      head_boundary  = 1'b0;
      head_ib_ext    = '0;
      group_ext      = '0;
      bank_ext       = '0;
      queue_busy     = 32'(queue_scope_ff) < SCOPES;

      // Issue reports are taken first; they free the scope and start its hold-off.
      for (int s = 0; s < SCOPES; s++) begin
         awaiting_in[s]      = awaiting_ff[s];
         boundary_bank_in[s] = boundary_bank_ff[s];
         allowed_time_in[s]  = allowed_time_ff[s];
         if (step_fire && req_item.issue_valid && 32'(req_item.issue_scope) == s &&
             awaiting_ff[s] &&
             CMP_W'(boundary_bank_ff[s]) == CMP_W'(req_item.issue_flat_bank)) begin
            awaiting_in[s]     = 1'b0;
            allowed_time_in[s] = clock_next + TIME_W'(recovery_time_ff);
         end
      end

      for (int s = 0; s < SCOPES; s++) begin
         if (awaiting_in[s] || clock_next < allowed_time_in[s]) begin
            seed_ok = 1'b0;
         end
      end

      if (step_fire) begin
         clock_count_in = clock_next;
         rsp_valid_in   = 1'b1;
         rsp_item_in    = '0;

         if (queue_busy) begin
            head_valid = 1'b1;
         end else if (clock_next >= next_time_ff && seed_ok) begin
            head_valid  = 1'b1;
            head_scope  = '0;
            // A round bank beyond the stack IDs in use falls back to bank 0.
            if (SCNT_W'(round_sid_ff) < stacks_used) begin
               head_sid = round_sid_ff;
               head_ib  = round_ib_ff;
            end else begin
               head_sid = '0;
               head_ib  = '0;
            end
            queue_sid_in   = head_sid;
            queue_ib_in    = head_ib;
            queue_scope_in = '0;
            if (head_ib == IB_W'(BANKS_PER_STACK_ID - 1)) begin
               round_ib_in  = '0;
               round_sid_in = (head_sid == last_sid) ? '0 : head_sid + SID_W'(1);
            end else begin
               round_ib_in  = head_ib + IB_W'(1);
               round_sid_in = head_sid;
            end
            next_time_in = next_time_ff + TIME_W'(refresh_interval_ff);
         end

         // A head queued under a wider setting ends a block at any multiple
         // of the stack IDs now in use.
         for (int k = 1; k <= STACK_IDS; k++) begin
            if (32'(head_sid) + 1 == k * 32'(stacks_used)) begin
               sid_block_end = 1'b1;
            end
         end

         head_flat     = FB_W'(32'(head_sid) * BANKS_PER_STACK_ID) + FB_W'(head_ib);
         head_boundary = (head_ib == IB_W'(BANKS_PER_STACK_ID - 1)) &&
                         (block_per_stack_id_ff || sid_block_end);
         head_ib_ext   = EW'(head_ib);
         group_ext     = head_ib_ext >> shift_used;
         bank_ext      = head_ib_ext & ((EW'(1) << shift_used) - EW'(1));

         if (head_valid) begin
            rsp_item_in.offer_valid      = 1'b1;
            rsp_item_in.offer_sent       = req_item.accept;
            rsp_item_in.offer_scope      = head_scope[0];
            rsp_item_in.offer_stack_id   = 2'(head_sid);
            rsp_item_in.offer_bank_group = group_ext[3:0];
            rsp_item_in.offer_bank       = bank_ext[3:0];
            if (req_item.accept) begin
               queue_scope_in = head_scope + SC_W'(1);
               // The last bank of a refresh block waits for its issue report.
               for (int s = 0; s < SCOPES; s++) begin
                  if (head_boundary && 32'(head_scope) == s) begin
                     awaiting_in[s]      = 1'b1;
                     boundary_bank_in[s] = head_flat;
                  end
               end
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Writing the interval restarts the deadline from the present clock.
      if (csr_write && csr_index == REG_REFRESH_INTERVAL) begin
         next_time_in = clock_count_ff + TIME_W'(pwdata[15:0]);
      end
   end

   always_comb begin
      case (csr_index)
         REG_REFRESH_INTERVAL:   prdata = CSR_DATA_W'(refresh_interval_ff);
         REG_RECOVERY_TIME:      prdata = CSR_DATA_W'(recovery_time_ff);
         REG_STACK_IDS_IN_USE:   prdata = CSR_DATA_W'(stack_ids_in_use_ff);
         REG_BLOCK_PER_STACK_ID: prdata = CSR_DATA_W'(block_per_stack_id_ff);
         REG_BANK_GROUP_SHIFT:   prdata = CSR_DATA_W'(bank_group_shift_ff);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_interval_ff   <= RESET_REFRESH_INTERVAL;
         recovery_time_ff      <= RESET_RECOVERY_TIME;
         stack_ids_in_use_ff   <= RESET_STACK_IDS_IN_USE;
         block_per_stack_id_ff <= RESET_BLOCK_PER_STACK_ID;
         bank_group_shift_ff   <= RESET_BANK_GROUP_SHIFT;
      end else if (csr_write) begin
         case (csr_index)
            REG_REFRESH_INTERVAL:   refresh_interval_ff   <= pwdata[15:0];
            REG_RECOVERY_TIME:      recovery_time_ff      <= pwdata[11:0];
            REG_STACK_IDS_IN_USE:   stack_ids_in_use_ff   <= pwdata[2:0];
            REG_BLOCK_PER_STACK_ID: block_per_stack_id_ff <= pwdata[0];
            REG_BANK_GROUP_SHIFT:   bank_group_shift_ff   <= pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_count_ff <= '0;
         next_time_ff   <= TIME_W'(RESET_REFRESH_INTERVAL);
         round_sid_ff   <= '0;
         round_ib_ff    <= '0;
         queue_sid_ff   <= '0;
         queue_ib_ff    <= '0;
         queue_scope_ff <= SC_W'(SCOPES);
         rsp_valid_ff   <= 1'b0;
         for (int s = 0; s < SCOPES; s++) begin
            awaiting_ff[s]      <= 1'b0;
            boundary_bank_ff[s] <= '0;
            allowed_time_ff[s]  <= '0;
         end
      end else begin
         clock_count_ff <= clock_count_in;
         next_time_ff   <= next_time_in;
         round_sid_ff   <= round_sid_in;
         round_ib_ff    <= round_ib_in;
         queue_sid_ff   <= queue_sid_in;
         queue_ib_ff    <= queue_ib_in;
         queue_scope_ff <= queue_scope_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int s = 0; s < SCOPES; s++) begin
            awaiting_ff[s]      <= awaiting_in[s];
            boundary_bank_ff[s] <= boundary_bank_in[s];
            allowed_time_ff[s]  <= allowed_time_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

>>> test/tb_hbm_per_bank_refresh_scheduler.sv
// Self-checking testbench for hbm_per_bank_refresh_scheduler: directed ticks,
// then phases of random ticks under several register settings and idle mixes.
// Depends on hbmprs_pkg and the scheduler RTL; no files or arguments are read.
module tb_hbm_per_bank_refresh_scheduler;
   import hbmprs_pkg::*;

   localparam int SCOPES             = 2;
   localparam int STACK_IDS          = 4;
   localparam int BANKS_PER_STACK_ID = 16;
   localparam int ROW_MAX            = 32;
   localparam int PHASE_MAX          = 16;
   localparam int EXP_DEPTH          = 64;

   typedef struct {
      hbmprs_req_type item;
      bit             typed;
      hbmprs_rsp_type want;
   } tick_row_type;

   typedef struct {
      logic [31:0] interval;
      logic [31:0] recovery;
      logic [31:0] stack_ids;
      logic [31:0] block_sid;
      logic [31:0] shift;
      int          items;
      int          send_idle;
      int          stall;
   } phase_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   hbmprs_req_type        req_item;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   hbmprs_rsp_type        rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor copy of the registers and the scheduler state.
   logic [15:0]           cfg_interval;
   logic [11:0]           cfg_recovery;
   logic [2:0]            cfg_stack_ids;
   logic                  cfg_block_sid;
   logic [2:0]            cfg_shift;
   logic [TIME_W-1:0]     tick_count;
   logic [TIME_W-1:0]     next_round_time;
   logic [5:0]            round_bank_q;
   logic [5:0]            head_bank;
   int unsigned           head_scope;
   logic                  waiting_report [SCOPES];
   logic [5:0]            report_bank [SCOPES];
   logic [TIME_W-1:0]     resume_time [SCOPES];

   // Expected results wait in a ring indexed by running write and read counts.
   hbmprs_rsp_type        expected_offers [EXP_DEPTH];
   int                    exp_wr = 0;
   int                    exp_rd = 0;
   hbmprs_rsp_type        oldest_offer;
   tick_row_type          tick_rows [ROW_MAX];
   int                    row_count = 0;
   phase_type             phases [PHASE_MAX];
   int                    phase_count = 0;

   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    fail_count = 0;
   int                    ticks_sent = 0;
   int                    offers_seen = 0;
   int                    offers_taken = 0;
   int                    reports_taken = 0;
   int                    settings_used = 0;

   hbm_per_bank_refresh_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Advances the predictor by one tick and returns the offer it expects.
   function automatic hbmprs_rsp_type next_offer(input hbmprs_req_type it);
      hbmprs_rsp_type r;
      int unsigned    n_banks;
      int unsigned    blk;
      int unsigned    sh;
      int unsigned    in_sid;
      bit             clear;
      r = '0;
      tick_count = tick_count + 1'b1;
      if (it.issue_valid && waiting_report[it.issue_scope] &&
          report_bank[it.issue_scope] == it.issue_flat_bank) begin
         waiting_report[it.issue_scope] = 1'b0;
         resume_time[it.issue_scope] = tick_count + cfg_recovery;
         reports_taken++;
      end
      n_banks = (cfg_stack_ids == 0) ? 1 : (cfg_stack_ids > STACK_IDS) ? STACK_IDS
                                                                       : cfg_stack_ids;
      n_banks = n_banks * BANKS_PER_STACK_ID;
      if (head_scope >= SCOPES) begin
         clear = 1'b1;
         for (int s = 0; s < SCOPES; s++) begin
            if (waiting_report[s] || tick_count < resume_time[s]) clear = 1'b0;
         end
         if (tick_count < next_round_time || !clear) return r;
         head_bank = (round_bank_q < n_banks) ? round_bank_q : 6'd0;
         head_scope = 0;
         round_bank_q = 6'((head_bank + 1) % n_banks);
         next_round_time = next_round_time + cfg_interval;
      end
      sh = (cfg_shift > MAX_BANK_GROUP_SHIFT) ? MAX_BANK_GROUP_SHIFT : cfg_shift;
      in_sid = head_bank % BANKS_PER_STACK_ID;
      r.offer_valid = 1'b1;
      r.offer_sent = it.accept;
      r.offer_scope = head_scope[0];
      r.offer_stack_id = 2'(head_bank / BANKS_PER_STACK_ID);
      r.offer_bank_group = 4'(in_sid >> sh);
      r.offer_bank = 4'(in_sid & ((1 << sh) - 1));
      if (it.accept) begin
         blk = cfg_block_sid ? BANKS_PER_STACK_ID : n_banks;
         // Accepting the last bank of a block makes the scope wait for its report.
         if ((head_bank + 1) % blk == 0) begin
            waiting_report[head_scope] = 1'b1;
            report_bank[head_scope] = head_bank;
         end
         head_scope++;
      end
      return r;
   endfunction

   // Mostly well-formed traffic: reports that close a pending block, some near
   // misses on the bank, and some stray reports.
   function automatic hbmprs_req_type pick_tick();
      hbmprs_req_type it;
      int unsigned    roll;
      int unsigned    s;
      it = 9'($urandom_range(511));
      it.accept = ($urandom_range(99) < 85);
      roll = $urandom_range(99);
      s = $urandom_range(1);
      if (!waiting_report[s]) s = 1 - s;
      if (waiting_report[s] && roll < 40) begin
         it.issue_valid = 1'b1;
         it.issue_scope = 1'(s);
         it.issue_flat_bank = report_bank[s];
      end else if (waiting_report[s] && roll < 50) begin
         it.issue_valid = 1'b1;
         it.issue_scope = 1'(s);
         it.issue_flat_bank = report_bank[s] ^ (6'd1 << $urandom_range(5));
      end else begin
         it.issue_valid = (roll >= 85);
      end
      return it;
   endfunction

   function automatic void add_row(input logic acc, input logic iv, input logic sc,
                                   input logic [5:0] fb, input bit typed,
                                   input hbmprs_rsp_type want);
      tick_row_type row;
      row.item = '{accept: acc, issue_valid: iv, issue_scope: sc, issue_flat_bank: fb};
      row.typed = typed;
      row.want = want;
      tick_rows[row_count] = row;
      row_count++;
   endfunction

   function automatic void add_phase(input logic [31:0] interval, recovery, stack_ids,
                                     block_sid, shift, input int items, send_idle,
                                     stall);
      phase_type p;
      p = '{interval, recovery, stack_ids, block_sid, shift, items, send_idle, stall};
      phases[phase_count] = p;
      phase_count++;
   endfunction

   function automatic void check_field(input string name, input logic [3:0] want,
                                       input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected item, expected none, got %h", $time, rsp_item);
            fail_count++;
         end else begin
            oldest_offer = expected_offers[exp_rd % EXP_DEPTH];
            exp_rd++;
            check_field("offer_valid", 4'(oldest_offer.offer_valid),
                        4'(rsp_item.offer_valid));
            check_field("offer_sent", 4'(oldest_offer.offer_sent),
                        4'(rsp_item.offer_sent));
            check_field("offer_scope", 4'(oldest_offer.offer_scope),
                        4'(rsp_item.offer_scope));
            check_field("offer_stack_id", 4'(oldest_offer.offer_stack_id),
                        4'(rsp_item.offer_stack_id));
            check_field("offer_bank_group", oldest_offer.offer_bank_group,
                        rsp_item.offer_bank_group);
            check_field("offer_bank", oldest_offer.offer_bank, rsp_item.offer_bank);
         end
         if (rsp_item.offer_valid === 1'b1) offers_seen++;
         if (rsp_item.offer_sent === 1'b1) offers_taken++;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_tick(input hbmprs_req_type it, input bit typed,
                            input hbmprs_rsp_type want);
      hbmprs_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      predicted = next_offer(it);
      expected_offers[exp_wr % EXP_DEPTH] = typed ? want : predicted;
      exp_wr++;
      ticks_sent++;
      @(negedge clock);
   endtask

   // Every item yields a result, so an empty store means the block is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_REFRESH_INTERVAL: begin
            cfg_interval = value[15:0];
            next_round_time = tick_count + cfg_interval;
         end
         REG_RECOVERY_TIME:      cfg_recovery = value[11:0];
         REG_STACK_IDS_IN_USE:   cfg_stack_ids = value[2:0];
         REG_BLOCK_PER_STACK_ID: cfg_block_sid = value[0];
         REG_BANK_GROUP_SHIFT:   cfg_shift = value[2:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // Idling between transfers keeps the port quiet before the next setup.
      @(negedge clock);
   endtask

   task automatic set_regs(input phase_type p);
      csr_write(REG_REFRESH_INTERVAL, p.interval);
      csr_write(REG_RECOVERY_TIME, p.recovery);
      csr_write(REG_STACK_IDS_IN_USE, p.stack_ids);
      csr_write(REG_BLOCK_PER_STACK_ID, p.block_sid);
      csr_write(REG_BANK_GROUP_SHIFT, p.shift);
      settings_used++;
   endtask

   task automatic run_rows(input int first, input int last);
      for (int i = first; i <= last; i++) begin
         send_tick(tick_rows[i].item, tick_rows[i].typed, tick_rows[i].want);
      end
   endtask

   initial begin
      hbmprs_rsp_type none;
      hbmprs_rsp_type held;
      hbmprs_rsp_type head0;
      hbmprs_rsp_type head1;
      phase_type      start_cfg;

      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_interval = RESET_REFRESH_INTERVAL;
      cfg_recovery = RESET_RECOVERY_TIME;
      cfg_stack_ids = RESET_STACK_IDS_IN_USE;
      cfg_block_sid = RESET_BLOCK_PER_STACK_ID;
      cfg_shift = RESET_BANK_GROUP_SHIFT;
      tick_count = '0;
      next_round_time = TIME_W'(RESET_REFRESH_INTERVAL);
      round_bank_q = '0;
      head_bank = '0;
      head_scope = SCOPES;
      for (int s = 0; s < SCOPES; s++) begin
         waiting_report[s] = 1'b0;
         report_bank[s] = '0;
         resume_time[s] = '0;
      end

      // After reset no round is due for a long while, so stray reports are
      // ignored and nothing is offered.
      none = '0;
      add_row(1'b0, 1'b0, 1'b0, 6'd0, 1'b1, none);
      add_row(1'b1, 1'b1, 1'b1, 6'd63, 1'b1, none);
      add_row(1'b1, 1'b1, 1'b0, 6'd0, 1'b1, none);
      add_row(1'b0, 1'b1, 1'b1, 6'd42, 1'b1, none);
      // With the interval register set to 1 the first round starts on the next tick:
      // bank 0 for scope 0, held while refused, then bank 0 for scope 1.
      held = '0;
      held.offer_valid = 1'b1;
      head0 = held;
      head0.offer_sent = 1'b1;
      head1 = head0;
      head1.offer_scope = 1'b1;
      add_row(1'b0, 1'b0, 1'b0, 6'd0, 1'b1, held);
      add_row(1'b0, 1'b1, 1'b1, 6'd21, 1'b1, held);
      add_row(1'b1, 1'b0, 1'b0, 6'd0, 1'b1, head0);
      add_row(1'b1, 1'b1, 1'b0, 6'd63, 1'b1, head1);
      add_row(1'b1, 1'b0, 1'b1, 6'd63, 1'b0, none);
      add_row(1'b1, 1'b1, 1'b1, 6'd0, 1'b0, none);
      add_row(1'b0, 1'b0, 1'b0, 6'd31, 1'b0, none);
      add_row(1'b1, 1'b1, 1'b0, 6'd32, 1'b0, none);
      add_row(1'b1, 1'b0, 1'b1, 6'd15, 1'b0, none);
      add_row(1'b1, 1'b1, 1'b1, 6'd16, 1'b0, none);
      add_row(1'b0, 1'b1, 1'b0, 6'd47, 1'b0, none);
      add_row(1'b1, 1'b0, 1'b0, 6'd48, 1'b0, none);
      add_row(1'b1, 1'b1, 1'b1, 6'd63, 1'b0, none);
      add_row(1'b1, 1'b1, 1'b0, 6'd1, 1'b0, none);
      add_row(1'b1, 1'b0, 1'b1, 6'd62, 1'b0, none);
      add_row(1'b1, 1'b1, 1'b0, 6'd3, 1'b0, none);

      // Later phases lower the stack ID count after wider ones, so the round
      // bank falls out of range; the long recovery comes last since it
      // stalls rounds.
      add_phase(32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 55, 0, 0);
      add_phase(32'd1, 32'd4, 32'd4, 32'd0, 32'd4, 55, 75, 0);
      add_phase(32'hABCD_0002, 32'hFFFF_F002, 32'd1, 32'd1, 32'd7, 55, 0, 75);
      add_phase(32'd1, 32'd3, 32'd0, 32'd0, 32'd1, 55, 34, 34);
      add_phase(32'd3, 32'd5, 32'd6, 32'd1, 32'd5, 55, 0, 0);
      add_phase(32'd1, 32'd1, 32'd3, 32'hFFFF_FFFE, 32'd3, 55, 75, 0);
      add_phase(32'd65535, 32'd1, 32'd2, 32'd1, 32'd2, 30, 0, 75);
      add_phase(32'd1, 32'd4095, 32'd2, 32'd0, 32'd6, 55, 34, 34);

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_rows(0, 3);
      settle();
      start_cfg = '{32'd1, 32'd1, 32'd4, 32'd0, 32'd4, 0, 0, 0};
      set_regs(start_cfg);
      run_rows(4, row_count - 1);

      for (int k = 0; k < phase_count; k++) begin
         settle();
         set_regs(phases[k]);
         send_idle_pct = phases[k].send_idle;
         stall_pct = phases[k].stall;
         for (int n = 0; n < phases[k].items; n++) begin
            send_tick(pick_tick(), 1'b0, none);
         end
      end

      settle();
      repeat (4) @(posedge clock);
      $display("Covered %0d ticks under %0d register settings: %0d offers, %0d taken,",
               ticks_sent, settings_used, offers_seen, offers_taken);
      $display("and %0d block-boundary issue reports released a scope.", reports_taken);
      if (fail_count == 0 && exp_wr == exp_rd) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
